[rtl/tfl_pkg.sv]
`timescale 1ns / 1ps

package tfl_pkg;

   localparam int ADDR_W  = 32;
   localparam int STAMP_W = 32;
   localparam int VIDX_W  = 4;
   localparam int CSR_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_TDATA_W = ((ADDR_W + 1 + VIDX_W + 7) / 8) * 8;

   localparam logic ACT_TRANSLATE = 1'b0;
   localparam logic ACT_FILL      = 1'b1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY         = 2'd2;

   localparam logic [CSR_W-1:0] RST_PAGE_SHIFT     = 5'd12;
   localparam logic [CSR_W-1:0] RST_ENTRIES_IN_USE = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN
   } st_type;

   // search item flags moving down the cell chain
   typedef struct packed {
      logic valid;
      logic found;
      logic free_found;
   } tok_ctl_type;

   // write command broadcast to all cells
   typedef struct packed {
      logic fill;
      logic touch;
   } wr_ctl_type;

endpackage

[rtl/tfl_cell.sv]
`timescale 1ns / 1ps

module tfl_cell #(
   parameter int PID_BITS   = 16,
   parameter int FRAME_BITS = 20,
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [CNT_W-1:0]             active_cnt,
   input  logic [PID_BITS-1:0]          key_pid,
   input  logic [tfl_pkg::ADDR_W-1:0]   key_page,
   input  tfl_pkg::tok_ctl_type         tok_ctl_i,
   input  logic [IDX_W-1:0]             found_idx_i,
   input  logic [FRAME_BITS-1:0]        found_frame_i,
   input  logic [IDX_W-1:0]             free_idx_i,
   input  logic [tfl_pkg::STAMP_W-1:0]  best_stamp_i,
   input  logic [IDX_W-1:0]             best_idx_i,
   output tfl_pkg::tok_ctl_type         tok_ctl_o,
   output logic [IDX_W-1:0]             found_idx_o,
   output logic [FRAME_BITS-1:0]        found_frame_o,
   output logic [IDX_W-1:0]             free_idx_o,
   output logic [tfl_pkg::STAMP_W-1:0]  best_stamp_o,
   output logic [IDX_W-1:0]             best_idx_o,
   input  tfl_pkg::wr_ctl_type          wr_ctl_i,
   input  logic [IDX_W-1:0]             wr_idx_i,
   input  logic [PID_BITS-1:0]          wr_pid_i,
   input  logic [tfl_pkg::ADDR_W-1:0]   wr_page_i,
   input  logic [FRAME_BITS-1:0]        wr_frame_i,
   input  logic [tfl_pkg::STAMP_W-1:0]  wr_stamp_i
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   logic                        valid_ff, valid_in;
   logic [PID_BITS-1:0]         pid_ff, pid_in;
   logic [tfl_pkg::ADDR_W-1:0]  page_ff, page_in;
   logic [FRAME_BITS-1:0]       frame_ff, frame_in;
   logic [tfl_pkg::STAMP_W-1:0] stamp_ff, stamp_in;

   tfl_pkg::tok_ctl_type        tok_ctl_ff, tok_ctl_in;
   logic [IDX_W-1:0]            found_idx_ff, found_idx_in;
   logic [FRAME_BITS-1:0]       found_frame_ff, found_frame_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [tfl_pkg::STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;

   logic active, match, sel, is_free;

   always_comb begin
      active  = MY_CNT < active_cnt;
      match   = active && valid_ff && (pid_ff == key_pid) && (page_ff == key_page);
      is_free = active && !valid_ff;
      sel     = wr_idx_i == MY_IDX;

      tok_ctl_in.valid      = tok_ctl_i.valid;
      tok_ctl_in.found      = tok_ctl_i.found | match;
      tok_ctl_in.free_found = tok_ctl_i.free_found | is_free;
      found_idx_in   = found_idx_i;
      found_frame_in = found_frame_i;
      free_idx_in    = free_idx_i;
      best_stamp_in  = best_stamp_i;
      best_idx_in    = best_idx_i;
      // lowest match and lowest free slot win
      if (match && !tok_ctl_i.found) begin
         found_idx_in   = MY_IDX;
         found_frame_in = frame_ff;
      end
      if (is_free && !tok_ctl_i.free_found) begin
         free_idx_in = MY_IDX;
      end
      // strict compare keeps the lowest slot on ties
      if (active && (stamp_ff < best_stamp_i)) begin
         best_stamp_in = stamp_ff;
         best_idx_in   = MY_IDX;
      end

      valid_in = valid_ff;
      pid_in   = pid_ff;
      page_in  = page_ff;
      frame_in = frame_ff;
      stamp_in = stamp_ff;
      if (sel && wr_ctl_i.fill) begin
         valid_in = 1'b1;
         pid_in   = wr_pid_i;
         page_in  = wr_page_i;
         frame_in = wr_frame_i;
         stamp_in = wr_stamp_i;
      end else if (sel && wr_ctl_i.touch) begin
         stamp_in = wr_stamp_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ctl_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         tok_ctl_ff <= tok_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff         <= pid_in;
      page_ff        <= page_in;
      frame_ff       <= frame_in;
      stamp_ff       <= stamp_in;
      found_idx_ff   <= found_idx_in;
      found_frame_ff <= found_frame_in;
      free_idx_ff    <= free_idx_in;
      best_stamp_ff  <= best_stamp_in;
      best_idx_ff    <= best_idx_in;
   end

   assign tok_ctl_o     = tok_ctl_ff;
   assign found_idx_o   = found_idx_ff;
   assign found_frame_o = found_frame_ff;
   assign free_idx_o    = free_idx_ff;
   assign best_stamp_o  = best_stamp_ff;
   assign best_idx_o    = best_idx_ff;

endmodule

[rtl/tlb_fifo_lru_translate_core.sv]
`timescale 1ns / 1ps

// Fully associative TLB, tagged by process id and page, FIFO or LRU refill.
// req_* carries one access: tuser selects translate or fill, tdata holds
// pid, logical address and (for fill) the frame returned after a miss.
// rsp_* returns one item per access: tuser is the hit flag, tdata the
// physical address, victim valid flag and the slot written by a fill.
// csr_* writes page_shift, entries_in_use and policy; write only when idle.
// Flow: a search item walks the row of ENTRIES cells, one cell a cycle,
// then the search state updates the entries and registers the result, and
// the drain state loads the output register. The core takes no new item
// until the previous one has reached the output register.
// A finished result waits in the output register while the next item is
// taken; if the receiver still stalls when that item finishes, the core
// holds it and keeps req_tready low until the output register drains.
// Reset clears all entry valid bits, the FIFO pointer, the use clock and
// restores page_shift 12, entries_in_use 16 and FIFO policy.

module tlb_fifo_lru_translate_core #(
   parameter int ENTRIES    = 16,
   parameter int PID_BITS   = 16,
   parameter int FRAME_BITS = 20,
   localparam int REQ_TDATA_W = ((PID_BITS + tfl_pkg::ADDR_W + FRAME_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pid, logical_address, frame, zero pad
   input  logic [REQ_TDATA_W-1:0]            req_tdata,
   // action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // physical_address, victim_valid, victim_index, zero pad
   output logic [tfl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [tfl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tfl_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > tfl_pkg::CSR_W) ? CNT_W : tfl_pkg::CSR_W;
   localparam int AW    = tfl_pkg::ADDR_W;
   localparam int SW    = tfl_pkg::STAMP_W;
   localparam int VW    = tfl_pkg::VIDX_W;
   localparam int PAD_W = tfl_pkg::RSP_TDATA_W - AW - 1 - VW;

   // configuration
   logic [tfl_pkg::CSR_W-1:0] shift_ff, shift_in;
   logic [tfl_pkg::CSR_W-1:0] eiu_ff, eiu_in;
   logic                      policy_ff, policy_in;

   // control
   tfl_pkg::st_type  state_ff, state_in;
   logic             head_valid_ff, head_valid_in;
   logic [IDX_W-1:0] fifo_ff, fifo_in;
   logic [SW-1:0]    clock_ff, clock_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // access key
   logic                  key_act_ff;
   logic [PID_BITS-1:0]   key_pid_ff;
   logic [AW-1:0]         key_addr_ff;
   logic [AW-1:0]         key_page_ff;
   logic [FRAME_BITS-1:0] key_frame_ff;

   // finished result and output register
   logic          res_hit_ff, res_hit_in;
   logic [AW-1:0] res_phys_ff, res_phys_in;
   logic          res_vv_ff, res_vv_in;
   logic [VW-1:0] res_vi_ff, res_vi_in;
   logic          out_hit_ff, out_hit_in;
   logic [AW-1:0] out_phys_ff, out_phys_in;
   logic          out_vv_ff, out_vv_in;
   logic [VW-1:0] out_vi_ff, out_vi_in;

   // cell chain
   tfl_pkg::tok_ctl_type  tok_ctl     [ENTRIES+1];
   logic [IDX_W-1:0]      found_idx   [ENTRIES+1];
   logic [FRAME_BITS-1:0] found_frame [ENTRIES+1];
   logic [IDX_W-1:0]      free_idx    [ENTRIES+1];
   logic [SW-1:0]         best_stamp  [ENTRIES+1];
   logic [IDX_W-1:0]      best_idx    [ENTRIES+1];
   logic [ENTRIES:0]      tok_valid_vec;

   tfl_pkg::wr_ctl_type   wr_ctl;
   logic [IDX_W-1:0]      wr_idx;

   logic [PID_BITS-1:0]   req_pid;
   logic [AW-1:0]         req_addr;
   logic [FRAME_BITS-1:0] req_frame;
   logic                  req_accept;
   logic [CNT_W-1:0]      n_active;
   logic [CMP_W-1:0]      eiu_ext;
   logic [AW-1:0]         offset;
   logic [FRAME_BITS-1:0] frm_sel;
   logic [AW-1:0]         phys_raw;
   logic [IDX_W-1:0]      slot;
   logic                  out_free;

   assign req_pid    = req_tdata[PID_BITS-1:0];
   assign req_addr   = req_tdata[PID_BITS +: AW];
   assign req_frame  = req_tdata[PID_BITS+AW +: FRAME_BITS];
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      eiu_ext = CMP_W'(eiu_ff);
      if (eiu_ext > CMP_W'(ENTRIES)) begin
         n_active = CNT_W'(ENTRIES);
      end else begin
         n_active = CNT_W'(eiu_ext);
      end
   end

   // head of the chain
   assign tok_ctl[0]     = '{valid: head_valid_ff, found: 1'b0, free_found: 1'b0};
   assign found_idx[0]   = '0;
   assign found_frame[0] = '0;
   assign free_idx[0]    = '0;
   assign best_stamp[0]  = '1;
   assign best_idx[0]    = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      tfl_cell #(
         .PID_BITS   (PID_BITS),
         .FRAME_BITS (FRAME_BITS),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W),
         .INDEX      (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .active_cnt    (n_active),
         .key_pid       (key_pid_ff),
         .key_page      (key_page_ff),
         .tok_ctl_i     (tok_ctl[g]),
         .found_idx_i   (found_idx[g]),
         .found_frame_i (found_frame[g]),
         .free_idx_i    (free_idx[g]),
         .best_stamp_i  (best_stamp[g]),
         .best_idx_i    (best_idx[g]),
         .tok_ctl_o     (tok_ctl[g+1]),
         .found_idx_o   (found_idx[g+1]),
         .found_frame_o (found_frame[g+1]),
         .free_idx_o    (free_idx[g+1]),
         .best_stamp_o  (best_stamp[g+1]),
         .best_idx_o    (best_idx[g+1]),
         .wr_ctl_i      (wr_ctl),
         .wr_idx_i      (wr_idx),
         .wr_pid_i      (key_pid_ff),
         .wr_page_i     (key_page_ff),
         .wr_frame_i    (key_frame_ff),
         .wr_stamp_i    (clock_ff)
      );
   end

   for (genvar g = 0; g <= ENTRIES; g++) begin : g_vld
      assign tok_valid_vec[g] = tok_ctl[g].valid;
   end

   // configuration writes
   always_comb begin
      shift_in  = shift_ff;
      eiu_in    = eiu_ff;
      policy_in = policy_ff;
      if (csr_we) begin
         unique case (csr_index)
            tfl_pkg::CSR_PAGE_SHIFT:     shift_in  = csr_wdata;
            tfl_pkg::CSR_ENTRIES_IN_USE: eiu_in    = csr_wdata;
            tfl_pkg::CSR_POLICY:         policy_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer and replacement decision at the chain tail
   always_comb begin
      offset   = key_addr_ff & ~({AW{1'b1}} << shift_ff);
      frm_sel  = (key_act_ff == tfl_pkg::ACT_FILL) ? key_frame_ff : found_frame[ENTRIES];
      phys_raw = (AW'(frm_sel) << shift_ff) | offset;
      out_free = !rsp_valid_ff || rsp_tready;

      if (!tok_ctl[ENTRIES].free_found && (policy_ff == tfl_pkg::POLICY_FIFO)) begin
         slot = (CNT_W'(fifo_ff) < n_active) ? fifo_ff : '0;
      end else if (!tok_ctl[ENTRIES].free_found) begin
         slot = best_idx[ENTRIES];
      end else begin
         slot = free_idx[ENTRIES];
      end

      state_in      = state_ff;
      req_tready    = 1'b0;
      head_valid_in = 1'b0;
      fifo_in       = fifo_ff;
      clock_in      = clock_ff;
      wr_ctl        = '0;
      wr_idx        = found_idx[ENTRIES];
      res_hit_in    = res_hit_ff;
      res_phys_in   = res_phys_ff;
      res_vv_in     = res_vv_ff;
      res_vi_in     = res_vi_ff;
      out_hit_in    = out_hit_ff;
      out_phys_in   = out_phys_ff;
      out_vv_in     = out_vv_ff;
      out_vi_in     = out_vi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         tfl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               head_valid_in = 1'b1;
               state_in      = tfl_pkg::ST_SEARCH;
            end
         end
         tfl_pkg::ST_SEARCH: begin
            if (tok_ctl[ENTRIES].valid) begin
               clock_in = clock_ff + SW'(1);
               res_vv_in = 1'b0;
               res_vi_in = '0;
               if (key_act_ff == tfl_pkg::ACT_TRANSLATE) begin
                  res_hit_in   = tok_ctl[ENTRIES].found;
                  res_phys_in  = tok_ctl[ENTRIES].found ? phys_raw : '0;
                  wr_ctl.touch = tok_ctl[ENTRIES].found;
               end else begin
                  res_hit_in  = 1'b0;
                  res_phys_in = phys_raw;
                  // disabled TLB stores nothing
                  if (n_active != '0) begin
                     wr_ctl.fill = 1'b1;
                     wr_idx      = slot;
                     res_vv_in   = !tok_ctl[ENTRIES].free_found;
                     res_vi_in   = VW'(slot);
                     if (!tok_ctl[ENTRIES].free_found &&
                         (policy_ff == tfl_pkg::POLICY_FIFO)) begin
                        fifo_in = (slot == IDX_W'(ENTRIES - 1)) ? '0 : slot + IDX_W'(1);
                     end
                  end
               end
               state_in = tfl_pkg::ST_DRAIN;
            end
         end
         tfl_pkg::ST_DRAIN: begin
            if (out_free) begin
               out_hit_in   = res_hit_ff;
               out_phys_in  = res_phys_ff;
               out_vv_in    = res_vv_ff;
               out_vi_in    = res_vi_ff;
               rsp_valid_in = 1'b1;
               state_in     = tfl_pkg::ST_IDLE;
            end
         end
         default: state_in = tfl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tfl_pkg::ST_IDLE;
         head_valid_ff <= 1'b0;
         fifo_ff       <= '0;
         clock_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         shift_ff      <= tfl_pkg::RST_PAGE_SHIFT;
         eiu_ff        <= tfl_pkg::RST_ENTRIES_IN_USE;
         policy_ff     <= tfl_pkg::POLICY_FIFO;
      end else begin
         state_ff      <= state_in;
         head_valid_ff <= head_valid_in;
         fifo_ff       <= fifo_in;
         clock_ff      <= clock_in;
         rsp_valid_ff  <= rsp_valid_in;
         shift_ff      <= shift_in;
         eiu_ff        <= eiu_in;
         policy_ff     <= policy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         key_act_ff   <= req_tuser;
         key_pid_ff   <= req_pid;
         key_addr_ff  <= req_addr;
         key_page_ff  <= req_addr >> shift_ff;
         key_frame_ff <= req_frame;
      end
      res_hit_ff  <= res_hit_in;
      res_phys_ff <= res_phys_in;
      res_vv_ff   <= res_vv_in;
      res_vi_ff   <= res_vi_in;
      out_hit_ff  <= out_hit_in;
      out_phys_ff <= out_phys_in;
      out_vv_ff   <= out_vv_in;
      out_vi_ff   <= out_vi_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_vi_ff, out_vv_ff, out_phys_ff};

   // at most one search item in the cell row
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one search item in the cell row");

   // the chain tail only fires while searching
   a_tail_state: assert property (@(posedge clock) disable iff (reset)
      tok_ctl[ENTRIES].valid |-> state_ff == tfl_pkg::ST_SEARCH)
      else $error("search item left the chain outside search state");

   // a hit never reports a victim
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !out_vv_ff)
      else $error("hit result carries a victim");

   // an entry write happens only as a search item leaves the row
   a_write_at_tail: assert property (@(posedge clock) disable iff (reset)
      (wr_ctl.fill || wr_ctl.touch) |-> tok_ctl[ENTRIES].valid && !(wr_ctl.fill && wr_ctl.touch))
      else $error("entry write without a finishing search item");

   // an accepted item starts a search on the next cycle
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == tfl_pkg::ST_SEARCH && head_valid_ff)
      else $error("accepted item did not enter the cell row");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int TLB_SLOTS = 16;
   localparam int REQ_W = 72;
   // index with no register behind it; a write there must change nothing
   localparam logic [tfl_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        action;
      logic [15:0] pid;
      logic [31:0] laddr;
      logic [19:0] frame;
   } access_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] phys;
      logic        vvalid;
      logic [3:0]  vidx;
   } xlate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tfl_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_we = 1'b0;
   logic [tfl_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [tfl_pkg::CSR_W-1:0]       csr_wdata = '0;

   tlb_fifo_lru_translate_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow TLB state and registers
   logic        tlb_valid [TLB_SLOTS];
   logic [15:0] tlb_pid   [TLB_SLOTS];
   logic [31:0] tlb_page  [TLB_SLOTS];
   logic [19:0] tlb_frame [TLB_SLOTS];
   logic [31:0] tlb_stamp [TLB_SLOTS];
   int          fifo_ptr = 0;
   logic [31:0] use_clock = '0;
   logic [4:0]  shift_cfg = tfl_pkg::RST_PAGE_SHIFT;
   logic [4:0]  slots_cfg = tfl_pkg::RST_ENTRIES_IN_USE;
   logic        policy_cfg = tfl_pkg::POLICY_FIFO;

   access_type access_queue [$];
   xlate_type  xlate_expected [$];
   access_type bus_access;
   xlate_type  predicted;
   xlate_type  want;
   int      error_count = 0;
   int      accepted_count = 0;
   int      req_wait = 0;
   int      rsp_wait = 0;
   int      hold_left = 0;
   int      next_hold = 250;
   bit      calm = 1'b0;

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 4));
   endfunction

   function automatic logic [31:0] phys_of(input logic [19:0] f, input logic [4:0] sh,
                                           input logic [31:0] off);
      return ({12'd0, f} << sh) + off;
   endfunction

   // lookup or refill against the shadow TLB; one result per access
   task automatic tlb_access(input access_type a, output xlate_type r);
      logic [31:0] pg;
      logic [31:0] off;
      logic [4:0]  sh;
      int          n;
      int          slot;
      logic        found;
      r = '0;
      sh = shift_cfg;
      pg = a.laddr >> sh;
      off = a.laddr & ((32'h1 << sh) - 32'h1);
      n = (slots_cfg > TLB_SLOTS) ? TLB_SLOTS : int'(slots_cfg);
      if (a.action == tfl_pkg::ACT_TRANSLATE) begin
         found = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!found && tlb_valid[i] && tlb_pid[i] == a.pid && tlb_page[i] == pg) begin
               found = 1'b1;
               r.hit = 1'b1;
               r.phys = phys_of(tlb_frame[i], sh, off);
               tlb_stamp[i] = use_clock;
            end
         end
      end else begin
         r.phys = phys_of(a.frame, sh, off);
         if (n != 0) begin
            slot = n;
            for (int i = 0; i < n; i++) begin
               if (slot == n && !tlb_valid[i]) slot = i;
            end
            if (slot == n) begin
               if (policy_cfg == tfl_pkg::POLICY_FIFO) begin
                  // stale pointer past the active range restarts at slot 0
                  slot = (fifo_ptr < n) ? fifo_ptr : 0;
                  fifo_ptr = (slot + 1) % TLB_SLOTS;
               end else begin
                  slot = 0;
                  for (int i = 1; i < n; i++) begin
                     if (tlb_stamp[i] < tlb_stamp[slot]) slot = i;
                  end
               end
               r.vvalid = 1'b1;
            end
            tlb_valid[slot] = 1'b1;
            tlb_pid[slot]   = a.pid;
            tlb_page[slot]  = pg;
            tlb_frame[slot] = a.frame;
            tlb_stamp[slot] = use_clock;
            r.vidx = 4'(slot);
         end
      end
      use_clock = use_clock + 32'd1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      error_count++;
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, exp_val);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         req_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            tlb_access(bus_access, predicted);
            xlate_expected.push_back(predicted);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait != 0) begin
               req_wait <= req_wait - 1;
               req_tvalid <= 1'b0;
            end else if (access_queue.size() != 0) begin
               bus_access = access_queue.pop_front();
               req_tdata <= {4'd0, bus_access.frame, bus_access.laddr, bus_access.pid};
               req_tuser <= bus_access.action;
               req_tvalid <= 1'b1;
               req_wait <= draw_wait();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver stall so the core backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         next_hold <= 250;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_count >= next_hold) begin
         hold_left <= 300;
         next_hold <= next_hold + 600;
      end
   end

   // result monitor and ready control
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (xlate_expected.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[31:0], 32'd0);
            end else begin
               want = xlate_expected.pop_front();
               if (rsp_tuser !== want.hit)
                  report_mismatch("hit", 32'(rsp_tuser), 32'(want.hit));
               if (rsp_tdata[31:0] !== want.phys)
                  report_mismatch("physical_address", rsp_tdata[31:0], want.phys);
               if (rsp_tdata[32] !== want.vvalid)
                  report_mismatch("victim_valid", 32'(rsp_tdata[32]), 32'(want.vvalid));
               if (rsp_tdata[36:33] !== want.vidx)
                  report_mismatch("victim_index", 32'(rsp_tdata[36:33]), 32'(want.vidx));
               if (rsp_tdata[tfl_pkg::RSP_TDATA_W-1:37] !== '0)
                  report_mismatch("tdata pad", 32'(rsp_tdata[tfl_pkg::RSP_TDATA_W-1:37]),
                                  32'd0);
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_wait <= draw_wait();
            rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (rsp_wait == 0) rsp_tready <= 1'b1;
            else rsp_wait <= rsp_wait - 1;
         end
      end
   end

   task automatic push_access(input logic act, input logic [15:0] p, input logic [31:0] a,
                              input logic [19:0] f);
      access_queue.push_back(access_type'{act, p, a, f});
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (access_queue.size() != 0 || req_tvalid || xlate_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [tfl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tfl_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tfl_pkg::CSR_PAGE_SHIFT:     shift_cfg = val;
         tfl_pkg::CSR_ENTRIES_IN_USE: slots_cfg = val;
         tfl_pkg::CSR_POLICY:         policy_cfg = val[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [4:0] sh, input logic [4:0] cnt, input logic pol);
      csr_write(tfl_pkg::CSR_PAGE_SHIFT, sh);
      csr_write(tfl_pkg::CSR_ENTRIES_IN_USE, cnt);
      csr_write(tfl_pkg::CSR_POLICY, {4'd0, pol});
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [19:0] draw_frame();
      case ($urandom_range(0, 7))
         0: return 20'h0;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] page_addr(input logic [31:0] pg);
      return (pg << shift_cfg) | ($urandom & ((32'h1 << shift_cfg) - 32'h1));
   endfunction

   // mostly miss/fill/retranslate sequences over a small working set, some noise
   task automatic fill_random(input int count);
      logic [15:0] pool_pid [24];
      logic [31:0] pool_page [24];
      int          pool_n;
      int          pushed;
      int          k;
      int          r;
      pool_n = $urandom_range(4, 24);
      for (int i = 0; i < pool_n; i++) begin
         pool_pid[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
         pool_page[i] = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : 32'($urandom);
      end
      pushed = 0;
      while (pushed < count) begin
         k = $urandom_range(0, pool_n - 1);
         r = $urandom_range(0, 9);
         if (r <= 4) begin
            push_access(tfl_pkg::ACT_TRANSLATE, pool_pid[k], page_addr(pool_page[k]),
                        draw_frame());
            push_access(tfl_pkg::ACT_FILL, pool_pid[k], page_addr(pool_page[k]),
                        draw_frame());
            push_access(tfl_pkg::ACT_TRANSLATE, pool_pid[k], page_addr(pool_page[k]),
                        draw_frame());
            pushed += 3;
         end else if (r <= 7) begin
            push_access(tfl_pkg::ACT_TRANSLATE, pool_pid[k], page_addr(pool_page[k]),
                        draw_frame());
            pushed++;
         end else if (r == 8) begin
            push_access(tfl_pkg::ACT_FILL, pool_pid[k], page_addr(pool_page[k]),
                        draw_frame());
            pushed++;
         end else begin
            push_access(1'($urandom), 16'($urandom), $urandom, 20'($urandom));
            pushed++;
         end
      end
   endtask

   task automatic run_phase(input logic [4:0] sh, input logic [4:0] cnt, input logic pol,
                            input int count, input bit quiet);
      wait_idle();
      configure(sh, cnt, pol);
      calm = quiet;
      fill_random(count);
   endtask

   initial begin
      #4_000_000;
      $display("tlb_fifo_lru_translate_core verification failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < TLB_SLOTS; i++) tlb_valid[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty miss, fills, hits, pid mismatch, duplicate entry
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0000, 32'h0000_0000, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h0000, 32'h0000_0000, 20'h00000);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0000, 32'h0000_0FFF, 20'hFFFFF);
      push_access(tfl_pkg::ACT_FILL,      16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'hFFFF, 32'hFFFF_F000, 20'h00000);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'hFFFE, 32'hFFFF_FFFF, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h0000, 32'h0000_0123, 20'h12345);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0000, 32'h0000_0456, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h5A5A, 32'h8000_0000, 20'hABCDE);

      // shrunk active range with LRU: stale slots ignored, victims chosen by age
      wait_idle();
      configure(5'd0, 5'd2, tfl_pkg::POLICY_LRU);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0000, 32'h0000_0000, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h0001, 32'h0000_0007, 20'h00003);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'hFFFF, 32'hFFFF_FFFF, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h0002, 32'h0000_0008, 20'h00004);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0002, 32'h0000_0008, 20'h00000);

      // largest shift, count above the slot total
      wait_idle();
      configure(5'd31, 5'd31, tfl_pkg::POLICY_FIFO);
      push_access(tfl_pkg::ACT_FILL,      16'h0003, 32'hFFFF_FFFF, 20'hFFFFF);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0003, 32'h8000_0000, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h0004, 32'h0000_0000, 20'h00001);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0004, 32'h7FFF_FFFF, 20'h00000);

      // disabled TLB, plus a write to the unused register index
      wait_idle();
      csr_write(CSR_UNUSED, 5'h1F);
      configure(5'd12, 5'd0, tfl_pkg::POLICY_FIFO);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0000, 32'h0000_0FFF, 20'h00000);
      push_access(tfl_pkg::ACT_FILL,      16'h0000, 32'h0000_0FFF, 20'hFFFFF);
      push_access(tfl_pkg::ACT_TRANSLATE, 16'h0000, 32'h0000_0FFF, 20'h00000);

      run_phase(5'd12, 5'd16, tfl_pkg::POLICY_FIFO, 165, 1'b0);
      run_phase(5'd12, 5'd16, tfl_pkg::POLICY_LRU,  165, 1'b1);
      run_phase(5'd0,  5'd1,  tfl_pkg::POLICY_LRU,  120, 1'b0);
      run_phase(5'd20, 5'd4,  tfl_pkg::POLICY_FIFO, 165, 1'b0);
      run_phase(5'd31, 5'd16, tfl_pkg::POLICY_LRU,  120, 1'b1);
      run_phase(5'd5,  5'd31, tfl_pkg::POLICY_FIFO, 165, 1'b0);
      run_phase(5'd0,  5'd0,  tfl_pkg::POLICY_LRU,  40,  1'b0);
      for (int p = 0; p < 4; p++)
         run_phase(5'($urandom_range(0, 20)), 5'($urandom_range(1, 16)),
                   1'($urandom_range(0, 1)), 165, p == 2);
      run_phase(5'd20, 5'd16, tfl_pkg::POLICY_LRU, 120, 1'b0);

      wait_idle();
      repeat (TLB_SLOTS + 8) @(posedge clock);
      if (error_count == 0 && xlate_expected.size() == 0) begin
         $display("tlb_fifo_lru_translate_core verification clean");
      end else begin
         $display("tlb_fifo_lru_translate_core verification failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/tfl_pkg.sv
rtl/tfl_cell.sv
rtl/tlb_fifo_lru_translate_core.sv
tb/sv/testbench.sv
